// ===== sv/scpr_pkg.sv =====
// Shared types, codes and constants of the sequenced CRC packet receiver.
// Holds the item structs and the CRC-16/CCITT-FALSE byte update; no dependencies.
`default_nettype none

package scpr_pkg;

  // Largest data payload of one packet, in bytes.
  localparam int MAX_DATA_BYTES = 256;
  localparam int HEADER_BYTES   = 4;

  localparam int POS_W = $clog2(HEADER_BYTES + MAX_DATA_BYTES + 1);
  localparam int LEN_W = 9;

  localparam logic [POS_W-1:0] HEADER_LEN = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] PACKET_END = POS_W'(HEADER_BYTES + MAX_DATA_BYTES);

  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam logic [1:0] KIND_NACK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       flash_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       reply_kind;
    logic [31:0]      write_address;
    logic [LEN_W-1:0] write_length;
    logic [31:0]      total_received;
  } out_item_t;

  // Advance the CRC by one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sequenced_crc_packet_receiver_unit.sv =====
// Top level of the sequenced CRC packet receiver: packet parse, checks, flash handshake.
// Depends on scpr_pkg and scpr_out_queue.
`default_nettype none

// Stop-and-wait receiver for update packets, one byte per item. A packet is a
// 16-bit sequence number and a 16-bit CRC (both little-endian) followed by up
// to MAX_DATA_BYTES data bytes; a CRC-16/CCITT-FALSE runs over the data. On the
// last byte the block answers NACK for a short, overlong, out-of-sequence or
// corrupt packet, or else a flash write request at image_base plus the
// committed total. A flash report item then commits the packet (ACK) or
// rejects it (NACK). A start item clears the session; image_base is kept.
// Every item is handled combinationally: the byte CRC update, the checks and
// the state update sit between the input port and the state and result
// registers, so one item is taken per clock while in_ready is high. Results
// go into a two-entry queue, so input items keep flowing while one result
// waits on out_ready; in_ready drops only when both entries are held. Write
// image_base through cfg_wen/cfg_wdata only while the block is idle.
module sequenced_crc_packet_receiver_unit
  import scpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item
);

  // Configuration.
  logic [31:0] image_base;

  // Packet state.
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             overlong_flag, overlong_flag_next;
  logic [15:0]      header_sequence, header_sequence_next;
  logic [15:0]      header_crc, header_crc_next;
  logic [15:0]      running_crc, running_crc_next;

  // Session state.
  logic [15:0]      expected_sequence, expected_sequence_next;
  logic [31:0]      committed_total, committed_total_next;
  logic             write_pending, write_pending_next;
  logic [LEN_W-1:0] pending_length, pending_length_next;

  logic       accept;
  logic       queue_full;
  logic       push;
  out_item_t  push_item;

  // Working values for the byte path.
  logic [POS_W-1:0] pos_upd;
  logic             over_upd;
  logic [15:0]      hseq_upd;
  logic [15:0]      hcrc_upd;
  logic [15:0]      crc_upd;
  logic             bad;
  logic [POS_W-1:0] payload_len;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // Hold every register unless the item says otherwise.
    byte_position_next     = byte_position;
    overlong_flag_next     = overlong_flag;
    header_sequence_next   = header_sequence;
    header_crc_next        = header_crc;
    running_crc_next       = running_crc;
    expected_sequence_next = expected_sequence;
    committed_total_next   = committed_total;
    write_pending_next     = write_pending;
    pending_length_next    = pending_length;
    push                   = 1'b0;
    push_item              = '0;

    // Fold the byte into the packet state: header bytes first, then data.
    pos_upd  = byte_position;
    over_upd = overlong_flag;
    hseq_upd = header_sequence;
    hcrc_upd = header_crc;
    crc_upd  = running_crc;
    if (byte_position < HEADER_LEN) begin
      unique case (byte_position[1:0])
        2'd0:    hseq_upd = {header_sequence[15:8], in_item.byte_value};
        2'd1:    hseq_upd = {in_item.byte_value, header_sequence[7:0]};
        2'd2:    hcrc_upd = {header_crc[15:8], in_item.byte_value};
        default: hcrc_upd = {in_item.byte_value, header_crc[7:0]};
      endcase
      pos_upd = byte_position + POS_W'(1);
    end else if (byte_position < PACKET_END) begin
      crc_upd = crc_byte(running_crc, in_item.byte_value);
      pos_upd = byte_position + POS_W'(1);
    end else begin
      // Drop the byte past the data limit; just mark the packet overlong.
      over_upd = 1'b1;
    end

    payload_len = pos_upd - HEADER_LEN;
    bad = (pos_upd < HEADER_LEN) || over_upd || (hseq_upd != expected_sequence) ||
          (crc_upd != hcrc_upd);

    if (accept) begin
      unique case (in_item.cmd)
        CMD_START: begin
          byte_position_next     = '0;
          overlong_flag_next     = 1'b0;
          header_sequence_next   = '0;
          header_crc_next        = '0;
          running_crc_next       = CRC_INIT;
          expected_sequence_next = '0;
          committed_total_next   = '0;
          write_pending_next     = 1'b0;
          pending_length_next    = '0;
        end
        CMD_REPORT: begin
          if (write_pending) begin
            write_pending_next  = 1'b0;
            pending_length_next = '0;
            push                = 1'b1;
            if (in_item.flash_ok) begin
              committed_total_next   = committed_total + 32'(pending_length);
              expected_sequence_next = expected_sequence + 16'd1;
              push_item.reply_kind   = KIND_ACK;
            end else begin
              push_item.reply_kind   = KIND_NACK;
            end
            push_item.total_received = committed_total_next;
          end
        end
        CMD_BYTE: begin
          // Ignore bytes, the last one too, while a flash write is outstanding.
          if (!write_pending) begin
            if (in_item.last_byte) begin
              push                     = 1'b1;
              push_item.total_received = committed_total;
              if (bad) begin
                push_item.reply_kind = KIND_NACK;
              end else begin
                push_item.reply_kind    = KIND_WRITE;
                push_item.write_address = image_base + committed_total;
                push_item.write_length  = LEN_W'(payload_len);
                write_pending_next      = 1'b1;
                pending_length_next     = LEN_W'(payload_len);
              end
              // Return the packet state to its reset values.
              byte_position_next   = '0;
              overlong_flag_next   = 1'b0;
              header_sequence_next = '0;
              header_crc_next      = '0;
              running_crc_next     = CRC_INIT;
            end else begin
              byte_position_next   = pos_upd;
              overlong_flag_next   = over_upd;
              header_sequence_next = hseq_upd;
              header_crc_next      = hcrc_upd;
              running_crc_next     = crc_upd;
            end
          end
        end
        default: begin
          // Unused command: drop it.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base        <= '0;
      byte_position     <= '0;
      overlong_flag     <= 1'b0;
      header_sequence   <= '0;
      header_crc        <= '0;
      running_crc       <= CRC_INIT;
      expected_sequence <= '0;
      committed_total   <= '0;
      write_pending     <= 1'b0;
      pending_length    <= '0;
    end else begin
      if (cfg_wen) begin
        image_base <= cfg_wdata;
      end
      byte_position     <= byte_position_next;
      overlong_flag     <= overlong_flag_next;
      header_sequence   <= header_sequence_next;
      header_crc        <= header_crc_next;
      running_crc       <= running_crc_next;
      expected_sequence <= expected_sequence_next;
      committed_total   <= committed_total_next;
      write_pending     <= write_pending_next;
      pending_length    <= pending_length_next;
    end
  end

  scpr_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== sv/scpr_out_queue.sv =====
// Two-entry result queue of the sequenced CRC packet receiver.
// Depends on scpr_pkg for the result item type.
`default_nettype none

module scpr_out_queue
  import scpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  out_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for sequenced_crc_packet_receiver_unit.
// Uses scpr_pkg for the item structs, command and reply codes, and the CRC constants.
// Replies are predicted in the bench; a directed table and random packet traffic drive the block.
module testbench;
  import scpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command code that the block leaves unused.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int          RESET_CYCLES = 5;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES = 120;
  localparam int          PHASE_ITEMS = 35;
  localparam longint      LIMIT_NS = 3_000_000;
  localparam logic [31:0] TABLE_BASE = 32'hFFFF_FFFF;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t reply;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  // Receiver state as predicted by the bench.
  logic [31:0] image_base_m;
  int          rx_pos;
  bit          rx_overlong;
  logic [31:0] rx_header;      // seq in [15:0], crc in [31:16], both little-endian
  logic [15:0] rx_crc;
  logic [15:0] next_seq;
  logic [31:0] committed_bytes;
  bit          flash_busy;
  logic [8:0]  flash_len;

  out_item_t   awaited_replies[$];
  table_row_t  directed_rows[$];

  int  errors = 0;
  int  counted_items = 0;
  int  checked_replies = 0;
  int  base_writes = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_request = 1'b0;

  sequenced_crc_packet_receiver_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC-16/CCITT-FALSE, one data byte, MSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    int          i;
    r = acc;
    for (i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void drop_packet();
    rx_pos = 0;
    rx_overlong = 1'b0;
    rx_header = '0;
    rx_crc = CRC_INIT;
  endfunction

  function automatic void reset_session();
    drop_packet();
    next_seq = '0;
    committed_bytes = '0;
    flash_busy = 1'b0;
    flash_len = '0;
  endfunction

  // Advance the predicted receiver by one accepted item and form its reply.
  task automatic advance_receiver(input in_item_t it, output bit produced,
                                  output bit ignored, output out_item_t rep);
    produced = 1'b0;
    ignored = 1'b0;
    rep = '0;
    case (it.cmd)
      CMD_START: begin
        reset_session();
      end
      CMD_REPORT: begin
        if (!flash_busy) begin
          ignored = 1'b1;
        end else begin
          flash_busy = 1'b0;
          produced = 1'b1;
          if (it.flash_ok) begin
            committed_bytes = committed_bytes + 32'(flash_len);
            next_seq = next_seq + 16'd1;
            rep.reply_kind = KIND_ACK;
          end else begin
            rep.reply_kind = KIND_NACK;
          end
          flash_len = '0;
          rep.total_received = committed_bytes;
        end
      end
      CMD_BYTE: begin
        if (flash_busy) begin
          ignored = 1'b1;
        end else begin
          if (rx_pos < HEADER_BYTES) begin
            rx_header[8*rx_pos +: 8] = it.byte_value;
            rx_pos++;
          end else if (rx_pos - HEADER_BYTES < MAX_DATA_BYTES) begin
            rx_crc = crc16_step(rx_crc, it.byte_value);
            rx_pos++;
          end else begin
            rx_overlong = 1'b1;
          end
          if (it.last_byte) begin
            produced = 1'b1;
            if (rx_pos < HEADER_BYTES || rx_overlong || rx_header[15:0] != next_seq ||
                rx_crc != rx_header[31:16]) begin
              rep.reply_kind = KIND_NACK;
            end else begin
              rep.reply_kind = KIND_WRITE;
              rep.write_address = image_base_m + committed_bytes;
              rep.write_length = 9'(rx_pos - HEADER_BYTES);
              flash_busy = 1'b1;
              flash_len = 9'(rx_pos - HEADER_BYTES);
            end
            rep.total_received = committed_bytes;
            drop_packet();
          end
        end
      end
      default: begin
        ignored = 1'b1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until taken, then predict. A typed reply replaces
  // the predicted one for directed rows.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_rep);
    int        gap;
    bit        produced;
    bit        ignored;
    out_item_t rep;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_receiver(it, produced, ignored, rep);
    if (!ignored) counted_items++;
    if (typed) begin
      awaited_replies.push_back(typed_rep);
    end else if (produced) begin
      awaited_replies.push_back(rep);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    in_item_t it;
    it.cmd = CMD_BYTE;
    it.byte_value = b;
    it.last_byte = last;
    it.flash_ok = 1'($urandom_range(0, 1));
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_control(input logic [1:0] cmd, input bit ok);
    in_item_t it;
    it.cmd = cmd;
    it.byte_value = 8'($urandom_range(0, 255));
    it.last_byte = 1'($urandom_range(0, 1));
    it.flash_ok = ok;
    send_item(it, 1'b0, '0);
  endtask

  // Header (seq, crc little-endian) then ndata random data bytes.
  task automatic send_packet(input logic [15:0] seq, input int ndata, input bit spoil_crc);
    logic [7:0]  data[$];
    logic [15:0] crc;
    int          i;
    crc = CRC_INIT;
    for (i = 0; i < ndata; i++) begin
      data.push_back(8'($urandom_range(0, 255)));
      if (i < MAX_DATA_BYTES) crc = crc16_step(crc, data[i]);
    end
    if (spoil_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(seq[7:0], 1'b0);
    send_byte(seq[15:8], 1'b0);
    send_byte(crc[7:0], 1'b0);
    send_byte(crc[15:8], ndata == 0);
    for (i = 0; i < ndata; i++) send_byte(data[i], i == ndata - 1);
  endtask

  // Close any open packet or write so the next packet starts clean.
  task automatic tidy_session();
    if (flash_busy) send_control(CMD_REPORT, 1'($urandom_range(0, 1)));
    if (rx_pos != 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while idle: after reset or after wait_drained.
  task automatic write_base(input logic [31:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    image_base_m = value;
    base_writes++;
  endtask

  function automatic out_item_t reply_of(input logic [1:0] kind, input logic [31:0] addr,
                                         input logic [8:0] len, input logic [31:0] total);
    out_item_t r;
    r.reply_kind = kind;
    r.write_address = addr;
    r.write_length = len;
    r.total_received = total;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [7:0] b, input bit last,
                                  input bit ok, input bit typed, input out_item_t rep);
    table_row_t row;
    row.item.cmd = cmd;
    row.item.byte_value = b;
    row.item.last_byte = last;
    row.item.flash_ok = ok;
    row.typed = typed;
    row.reply = rep;
    directed_rows.push_back(row);
  endfunction

  // Directed rows, walked right after reset with image_base at TABLE_BASE.
  function automatic void load_directed_table();
    logic [15:0] crc2;
    crc2 = crc16_step(crc16_step(CRC_INIT, 8'h00), 8'hFF);
    // report with no write outstanding: nothing comes back
    add_row(CMD_REPORT, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    // one-byte packet is short
    add_row(CMD_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1, reply_of(KIND_NACK, '0, '0, '0));
    // empty-data packet, seq 0, crc 0xFFFF: write of length 0 at the base
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'hFF, 1'b0, 1'b1, 1'b0, '0);
    add_row(CMD_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1, reply_of(KIND_WRITE, TABLE_BASE, '0, '0));
    // byte while the write is outstanding, even a last one, is dropped
    add_row(CMD_BYTE, 8'hAA, 1'b1, 1'b1, 1'b0, '0);
    add_row(CMD_REPORT, 8'hFF, 1'b1, 1'b1, 1'b1, reply_of(KIND_ACK, '0, '0, '0));
    // seq 1 with data 00 FF: write request checked by prediction
    add_row(CMD_BYTE, 8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, crc2[7:0], 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, crc2[15:8], 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b1, 1'b0, '0);
    add_row(CMD_BYTE, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
    // flash failure
    add_row(CMD_REPORT, 8'h55, 1'b0, 1'b0, 1'b1, reply_of(KIND_NACK, '0, '0, '0));
    // unused command
    add_row(CMD_SPARE, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
    // out-of-sequence packet (seq 0 while 1 is awaited)
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1, reply_of(KIND_NACK, '0, '0, '0));
    // right sequence, wrong CRC
    add_row(CMD_BYTE, 8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b1, 1'b0, 1'b1, reply_of(KIND_NACK, '0, '0, '0));
    // new session
    add_row(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0, '0);
  endfunction

  // One random transaction: mostly well-formed packets with their report,
  // the rest broken packets, stray commands and noise.
  task automatic run_transaction();
    int pick;
    int ndata;
    tidy_session();
    pick = $urandom_range(0, 99);
    ndata = ($urandom_range(0, 29) == 0) ? MAX_DATA_BYTES : $urandom_range(0, 12);
    if (pick < 60) begin
      send_packet(next_seq, ndata, 1'b0);
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_control(CMD_REPORT, $urandom_range(0, 6) != 0);
    end else if (pick < 70) begin
      send_packet(next_seq, ndata, 1'b1);
    end else if (pick < 78) begin
      send_packet(next_seq + 16'($urandom_range(1, 65535)), ndata, 1'b0);
    end else if (pick < 85) begin
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 86) begin
      send_packet(next_seq, MAX_DATA_BYTES + $urandom_range(1, 4), 1'b0);
    end else if (pick < 93) begin
      send_item(in_item_t'($urandom_range(0, 4095)), 1'b0, '0);
    end else if (pick < 97) begin
      send_control(($urandom_range(0, 1) != 0) ? CMD_REPORT : CMD_SPARE, 1'($urandom_range(0, 1)));
    end else begin
      send_control(CMD_START, 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall patterns in stretches, plus a long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : reply_sink
    rx_mode_t mode;
    int       stretch_left;
    bit       phase_bit;
    mode = RX_STREAM;
    stretch_left = 0;
    phase_bit = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        // hold off long enough for the output queue to fill and stall the input
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stretch_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        stretch_left = $urandom_range(10, 60);
      end
      stretch_left--;
      phase_bit = ~phase_bit;
      case (mode)
        RX_STREAM:    out_ready <= 1'b1;
        RX_RANDOM:    out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:    out_ready <= ($urandom_range(0, 3) == 0);
        RX_ALTERNATE: out_ready <= phase_bit;
        default:      out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Reply checking against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_reply(input out_item_t want, input out_item_t got);
    if (got.reply_kind !== want.reply_kind) begin
      $display("%0t: reply_kind expected %0d, got %0d", $time, want.reply_kind, got.reply_kind);
      errors++;
    end
    if (got.write_address !== want.write_address) begin
      $display("%0t: write_address expected %h, got %h", $time, want.write_address,
               got.write_address);
      errors++;
    end
    if (got.write_length !== want.write_length) begin
      $display("%0t: write_length expected %0d, got %0d", $time, want.write_length,
               got.write_length);
      errors++;
    end
    if (got.total_received !== want.total_received) begin
      $display("%0t: total_received expected %h, got %h", $time, want.total_received,
               got.total_received);
      errors++;
    end
  endtask

  always @(posedge clk) begin : reply_check
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with none expected, expected nothing, got %p", $time, out_item);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        check_reply(want, out_item);
        checked_replies++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] phase_base[4];
    int          target;
    int          p;
    phase_base[0] = 32'h0000_0000;
    phase_base[1] = 32'($urandom);
    phase_base[2] = 32'hFFFF_FF00;
    phase_base[3] = 32'h8000_0000;
    image_base_m = '0;
    reset_session();

    // hold reset, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the top base address
    write_base(TABLE_BASE);
    load_directed_table();
    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].typed,
                                         directed_rows[i].reply);

    // full-length packet, then one that runs past the data limit
    send_packet(next_seq, MAX_DATA_BYTES, 1'b0);
    send_control(CMD_REPORT, 1'b1);
    send_packet(next_seq, MAX_DATA_BYTES + 2, 1'b0);

    for (p = 0; p < 4; p++) begin
      // pause until every reply is back, then change the base
      wait_drained();
      write_base(phase_base[p]);
      if (p == 2) begin
        // back-to-back short packets against a held-off receiver
        tidy_session();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b1);
        gaps_on = 1'b1;
      end
      // one phase runs with no sender gaps at all
      gaps_on = (p != 3);
      target = counted_items + PHASE_ITEMS;
      while (counted_items < target) run_transaction();
      gaps_on = 1'b1;
    end

    wait_drained();
    $display("Run: %0d items taken, %0d replies checked, %0d image_base writes.",
             counted_items, checked_replies, base_writes);
    $display("Traffic: good, corrupt, out-of-sequence, short, full and overlong packets; "
             , "flash pass and fail; output stalls.");
    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
